>>> rtl/cps_pkg.sv
// Package for the crosspoint mux shift-register sequencer.
// Holds the command types, shadow bit masks and the word step decoder.
// No dependencies; every module of the block refers to it by scoped name.
package cps_pkg;

  localparam int CHAIN_BITS_DEF  = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int WORD_W = 32;

  // Shadow bit map: 4 CS2, 5 CS1, 6 strobe, 7 data, 8 reset,
  // 9..11 mux input address, 12..15 mux output address.
  localparam logic [WORD_W-1:0] CS_BOTH_M     = 32'h0000_0030;
  localparam logic [WORD_W-1:0] CS2_B         = 32'h0000_0010;
  localparam logic [WORD_W-1:0] CS1_B         = 32'h0000_0020;
  localparam logic [WORD_W-1:0] STROBE_B      = 32'h0000_0040;
  localparam logic [WORD_W-1:0] DATA_B        = 32'h0000_0080;
  localparam logic [WORD_W-1:0] RESET_B       = 32'h0000_0100;
  localparam logic [WORD_W-1:0] DATA_STROBE_M = 32'h0000_00C0;
  localparam logic [WORD_W-1:0] ADDR_M        = 32'h0000_FE00;
  localparam logic [WORD_W-1:0] ZERO_W        = 32'h0000_0000;
  localparam int               IN_ADDR_LSB   = 9;
  localparam int               OUT_ADDR_LSB  = 12;

  typedef enum logic [1:0] {
    OP_UPDATE  = 2'd0,
    OP_RESET   = 2'd1,
    OP_CONNECT = 2'd2,
    OP_IGNORE  = 2'd3
  } opcode_t;

  // Word position within one command
  typedef enum logic [1:0] {
    STEP_FIRST  = 2'd0,
    STEP_SECOND = 2'd1,
    STEP_THIRD  = 2'd2,
    STEP_TAIL   = 2'd3
  } step_t;

  typedef struct packed {
    opcode_t           op;
    logic [WORD_W-1:0] mask;       // masked update mask
    logic [WORD_W-1:0] bits;       // masked update values, or connect select word
    logic              last_pair;
  } cmd_t;

  typedef struct packed {
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] bits;
  } word_op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_LOAD,
    B_SHIFT,
    B_LATCH
  } back_state_t;

  function automatic word_op_t step_word(input cmd_t cmd, input step_t step);
    word_op_t w;
    w.mask = ZERO_W;
    w.bits = ZERO_W;
    unique case (cmd.op)
      OP_UPDATE: begin
        w.mask = cmd.mask;
        w.bits = cmd.bits;
      end
      OP_RESET: begin
        unique case (step)
          STEP_FIRST:  begin w.mask = CS_BOTH_M;            w.bits = CS_BOTH_M; end
          STEP_SECOND: begin w.mask = RESET_B | STROBE_B;   w.bits = RESET_B;   end
          STEP_THIRD:  begin w.mask = RESET_B;              w.bits = ZERO_W;    end
          default:     begin w.mask = STROBE_B;             w.bits = ZERO_W;    end
        endcase
      end
      OP_CONNECT: begin
        unique case (step)
          STEP_FIRST:  begin w.mask = DATA_STROBE_M;        w.bits = DATA_B;        end
          STEP_SECOND: begin w.mask = CS_BOTH_M | ADDR_M;   w.bits = cmd.bits;      end
          STEP_THIRD:  begin w.mask = DATA_STROBE_M;        w.bits = DATA_STROBE_M; end
          default:     begin w.mask = STROBE_B;             w.bits = ZERO_W;        end
        endcase
      end
      default: begin
        w.mask = ZERO_W;
        w.bits = ZERO_W;
      end
    endcase
    return w;
  endfunction

  function automatic step_t final_step(input cmd_t cmd);
    step_t s;
    if (cmd.op == OP_UPDATE) begin
      s = STEP_FIRST;
    end else if (cmd.last_pair) begin
      s = STEP_TAIL;
    end else begin
      s = STEP_THIRD;
    end
    return s;
  endfunction

endpackage

>>> rtl/crosspoint_mux_shift_register_sequencer.sv
// Top level of the crosspoint mux shift-register sequencer.
// Ties front end, command queue and back end together.
// Depends on cps_pkg, cps_front, cps_queue and cps_back.
//
//   channel | handshake          | payload
//   --------+--------------------+---------------------------------------------
//   input   | in_valid / in_stall | opcode update_mask update_bits in_addr
//           |                    | out_addr last_pair
//   output  | out_valid/out_stall| latched_word outputs_enabled last
//
// Each latched word passes through the back end as one load, CHAIN_BITS
// serial shifts and one latch, which waits while out_stall holds the output;
// the back end idles between commands. A masked update latches one word, a
// reset or connect three or four. The serial shifter sets the pace.
// Reset (rst, synchronous) clears shadow, queue, out_valid and outputs_enabled.
// The front keeps taking transactions while the queue has room; out_stall
// holds the latched word and halts the back end at its next latch.
module crosspoint_mux_shift_register_sequencer #(
  parameter int CHAIN_BITS  = cps_pkg::CHAIN_BITS_DEF,
  parameter int QUEUE_DEPTH = cps_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [31:0] update_mask,
  input  logic [31:0] update_bits,
  input  logic [2:0]  in_addr,
  input  logic [4:0]  out_addr,
  input  logic        last_pair,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] latched_word,
  output logic        outputs_enabled,
  output logic        last
);

  cps_pkg::qstat_t qstat;
  cps_pkg::cmd_t   push_cmd;
  cps_pkg::cmd_t   head;
  logic            push;
  logic            pop;

  // Classify and drop unused opcodes
  cps_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .update_mask (update_mask),
    .update_bits (update_bits),
    .in_addr     (in_addr),
    .out_addr    (out_addr),
    .last_pair   (last_pair),
    .qstat       (qstat),
    .push        (push),
    .cmd         (push_cmd)
  );

  // Decouple front from the slow serial back end
  cps_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  // Sequence words, shift them out and latch each one
  cps_back #(
    .CHAIN_BITS (CHAIN_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .qstat           (qstat),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .latched_word    (latched_word),
    .outputs_enabled (outputs_enabled),
    .last            (last)
  );

  // Every latch enables the register outputs
  a_enabled_with_word: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> outputs_enabled)
    else $error("word presented with outputs disabled");

  // Queue cannot report full and empty together
  a_queue_status: assert property (@(posedge clk) disable iff (rst)
    !(qstat.full && qstat.empty))
    else $error("queue status inconsistent");

  // A queued command is visible to the back end on the next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    push |=> !qstat.empty)
    else $error("pushed command lost");

  // Back end only retires a command while one is held
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

endmodule

>>> rtl/cps_front.sv
// Front end of the crosspoint mux sequencer: accepts and classifies items.
// Drops unused opcodes and prebuilds the connect select word.
// Depends on cps_pkg.
module cps_front (
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                opcode,
  input  logic [31:0]               update_mask,
  input  logic [31:0]               update_bits,
  input  logic [2:0]                in_addr,
  input  logic [4:0]                out_addr,
  input  logic                      last_pair,
  input  cps_pkg::qstat_t           qstat,
  output logic                      push,
  output cps_pkg::cmd_t             cmd
);

  cps_pkg::opcode_t            op;
  logic [cps_pkg::WORD_W-1:0]  cs_sel;
  logic [cps_pkg::WORD_W-1:0]  addr_bits;

  assign op = cps_pkg::opcode_t'(opcode);

  // Outputs 16..31 sit on the second chip
  assign cs_sel    = out_addr[4] ? cps_pkg::CS2_B : cps_pkg::CS1_B;
  assign addr_bits = (cps_pkg::WORD_W'(in_addr) << cps_pkg::IN_ADDR_LSB)
                   | (cps_pkg::WORD_W'(out_addr[3:0]) << cps_pkg::OUT_ADDR_LSB);

  assign in_stall = qstat.full;

  always_comb begin
    cmd.op        = op;
    cmd.last_pair = last_pair;
    if (op == cps_pkg::OP_UPDATE) begin
      cmd.mask = update_mask;
      cmd.bits = update_bits;
    end else begin
      cmd.mask = cps_pkg::ZERO_W;
      cmd.bits = cs_sel | addr_bits;
    end
  end

  // Unused opcode: take the transaction, queue nothing
  assign push = in_valid && !qstat.full && (op != cps_pkg::OP_IGNORE);

endmodule

>>> rtl/cps_queue.sv
// Command queue between front and back end of the mux sequencer.
// Small circular buffer of cps_pkg::cmd_t entries.
// Depends on cps_pkg.
module cps_queue #(
  parameter int DEPTH = cps_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  cps_pkg::cmd_t    push_cmd,
  input  logic             pop,
  output cps_pkg::cmd_t    head,
  output cps_pkg::qstat_t  qstat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cps_pkg::cmd_t      slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  assign qstat.full  = (count == CNT_W'(DEPTH));
  assign qstat.empty = (count == '0);
  assign head        = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/cps_back.sv
// Back end of the mux sequencer: applies each word step to the shadow,
// shifts the word through a model of the serial chain and latches it.
// Depends on cps_pkg.
module cps_back #(
  parameter int CHAIN_BITS = cps_pkg::CHAIN_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  cps_pkg::cmd_t    head,
  input  cps_pkg::qstat_t  qstat,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [31:0]      latched_word,
  output logic             outputs_enabled,
  output logic             last
);

  localparam int CNT_W = (CHAIN_BITS > 1) ? $clog2(CHAIN_BITS) : 1;

  cps_pkg::back_state_t        state, state_next;
  cps_pkg::step_t              step;
  logic [cps_pkg::WORD_W-1:0]  shadow;
  logic [cps_pkg::WORD_W-1:0]  shadow_next;
  logic [CHAIN_BITS-1:0]       sreg;
  logic [CHAIN_BITS-1:0]       chain;
  logic [CNT_W-1:0]            bit_cnt;
  cps_pkg::word_op_t           wop;
  logic                        load_word;
  logic                        do_shift;
  logic                        do_latch;
  logic                        final_word;
  logic                        out_free;

  assign wop         = cps_pkg::step_word(head, step);
  assign shadow_next = (shadow & ~wop.mask) | (wop.mask & wop.bits);
  assign final_word  = (step == cps_pkg::final_step(head));
  assign out_free    = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cps_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    load_word  = 1'b0;
    do_shift   = 1'b0;
    do_latch   = 1'b0;
    pop        = 1'b0;
    unique case (state)
      cps_pkg::B_IDLE: begin
        if (!qstat.empty) begin
          state_next = cps_pkg::B_LOAD;
        end
      end
      cps_pkg::B_LOAD: begin
        load_word  = 1'b1;
        state_next = cps_pkg::B_SHIFT;
      end
      cps_pkg::B_SHIFT: begin
        do_shift = 1'b1;
        if (bit_cnt == CNT_W'(CHAIN_BITS - 1)) begin
          state_next = cps_pkg::B_LATCH;
        end
      end
      cps_pkg::B_LATCH: begin
        if (out_free) begin
          do_latch = 1'b1;
          if (final_word) begin
            pop        = 1'b1;
            state_next = cps_pkg::B_IDLE;
          end else begin
            state_next = cps_pkg::B_LOAD;
          end
        end
      end
      default: state_next = cps_pkg::B_IDLE;
    endcase
  end

  // Shadow, step counter, output valid and enable are control state
  always_ff @(posedge clk) begin
    if (rst) begin
      shadow          <= '0;
      step            <= cps_pkg::STEP_FIRST;
      out_valid       <= 1'b0;
      outputs_enabled <= 1'b0;
    end else begin
      if (load_word) begin
        shadow <= shadow_next;
      end
      if (do_latch) begin
        step            <= final_word ? cps_pkg::STEP_FIRST : cps_pkg::step_t'(step + 2'd1);
        out_valid       <= 1'b1;
        outputs_enabled <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Serial chain: drive LSB first, chain fills from the far end
  always_ff @(posedge clk) begin
    if (load_word) begin
      sreg    <= CHAIN_BITS'(shadow_next);
      chain   <= '0;
      bit_cnt <= '0;
    end else if (do_shift) begin
      sreg    <= sreg >> 1;
      chain   <= {sreg[0], chain[CHAIN_BITS-1:1]};
      bit_cnt <= bit_cnt + CNT_W'(1);
    end
    if (do_latch) begin
      latched_word <= 32'(chain);
      last         <= final_word;
    end
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for crosspoint_mux_shift_register_sequencer.
// Needs cps_pkg and the RTL of the block; predicts every latched word itself.
module tb;
  import cps_pkg::*;

  // Latch mask for the configured chain length (all ones at 32 bits or more)
  localparam int          CHAIN_LEN  = CHAIN_BITS_DEF;
  localparam logic [31:0] CHAIN_MASK = (CHAIN_LEN >= 32) ? 32'hFFFF_FFFF :
                                       ((32'd1 << CHAIN_LEN) - 32'd1);
  // Long output hold-off, enough to back the block up into its input
  localparam int          HOLD_CYCLES = 1500;
  localparam int          TAIL_CYCLES = 300;

  // One latched word as the block should present it
  typedef struct packed {
    logic [31:0] word;
    logic        enabled;
    logic        fin;
  } latch_t;

  // One row of the directed stimulus; pin marks a hand-worked final word
  typedef struct {
    opcode_t     op;
    logic [31:0] m;
    logic [31:0] b;
    logic [2:0]  ia;
    logic [4:0]  oa;
    logic        lp;
    logic        pin;
    logic [31:0] pin_word;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  opcode = OP_UPDATE;
  logic [31:0] update_mask = '0;
  logic [31:0] update_bits = '0;
  logic [2:0]  in_addr = '0;
  logic [4:0]  out_addr = '0;
  logic        last_pair = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] latched_word;
  logic        outputs_enabled;
  logic        last;

  // Pinned expectation travels alongside the payload
  logic        pin_valid = 1'b0;
  logic [31:0] pin_word = '0;

  // Predictor state: shadow copy of the chain and the output-enable flag
  logic [31:0] shadow_q = '0;
  logic        outputs_on = 1'b0;
  latch_t      pending_latches[$];
  latch_t      head_latch;

  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_used = 1'b0;
  int unsigned hold_left = 0;

  int unsigned err_cnt = 0;
  int unsigned cmds_taken = 0;
  int unsigned ignored_cnt = 0;
  int unsigned words_checked = 0;
  int unsigned in_stall_cycles = 0;

  stim_row_t   directed_q[$];

  crosspoint_mux_shift_register_sequencer dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .opcode          (opcode),
    .update_mask     (update_mask),
    .update_bits     (update_bits),
    .in_addr         (in_addr),
    .out_addr        (out_addr),
    .last_pair       (last_pair),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .latched_word    (latched_word),
    .outputs_enabled (outputs_enabled),
    .last            (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Merge one word into the shadow copy and queue the latch it causes
  function automatic void latch_shadow(input logic [31:0] m, input logic [31:0] b,
                                       input logic fin);
    latch_t e;
    shadow_q   = (shadow_q & ~m) | (m & b);
    outputs_on = 1'b1;
    e.word     = shadow_q & CHAIN_MASK;
    e.enabled  = outputs_on;
    e.fin      = fin;
    pending_latches.push_back(e);
  endfunction

  // Expand one accepted command into its sequence of latched words
  function automatic void predict_latches(input opcode_t op, input logic [31:0] m,
                                          input logic [31:0] b, input logic [2:0] ia,
                                          input logic [4:0] oa, input logic lp);
    logic [31:0] sel;
    sel = (oa[4] ? CS2_B : CS1_B) | (32'(ia) << IN_ADDR_LSB) |
          (32'(oa[3:0]) << OUT_ADDR_LSB);
    case (op)
      OP_UPDATE: begin
        // last flag has no effect on an update
        latch_shadow(m, b, 1'b1);
      end
      OP_RESET: begin
        latch_shadow(CS_BOTH_M, CS_BOTH_M, 1'b0);
        latch_shadow(RESET_B | STROBE_B, RESET_B, 1'b0);
        latch_shadow(RESET_B, ZERO_W, !lp);
        if (lp) latch_shadow(STROBE_B, ZERO_W, 1'b1);
      end
      OP_CONNECT: begin
        latch_shadow(DATA_STROBE_M, DATA_B, 1'b0);
        latch_shadow(CS_BOTH_M | ADDR_M, sel, 1'b0);
        latch_shadow(DATA_STROBE_M, DATA_STROBE_M, !lp);
        if (lp) latch_shadow(STROBE_B, ZERO_W, 1'b1);
      end
      default: begin
        // unused opcode: no words, no state change
        ignored_cnt++;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  function automatic void report_mismatch(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    err_cnt++;
  endfunction

  // Take input transactions into the predictor, then compare output transactions
  // with the oldest queued latch. Both sides are sampled before this edge updates.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_stall) in_stall_cycles++;
      if (in_valid && !in_stall) begin
        cmds_taken++;
        predict_latches(opcode_t'(opcode), update_mask, update_bits, in_addr, out_addr,
                        last_pair);
        if (pin_valid && pending_latches.size() != 0)
          pending_latches[pending_latches.size() - 1].word = pin_word;
      end
      if (out_valid && !out_stall) begin
        words_checked++;
        if (pending_latches.size() == 0) begin
          $display("%0t: unexpected latched word, expected none, actual %h", $time,
                   latched_word);
          err_cnt++;
        end else begin
          head_latch = pending_latches.pop_front();
          if (latched_word !== head_latch.word)
            report_mismatch("latched_word", head_latch.word, latched_word);
          if (outputs_enabled !== head_latch.enabled)
            report_mismatch("outputs_enabled", 32'(head_latch.enabled),
                            32'(outputs_enabled));
          if (last !== head_latch.fin)
            report_mismatch("last", 32'(head_latch.fin), 32'(last));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall, or one long hold-off counted here
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (hold_req && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Idle at random, then offer one transaction and hold it until taken
  task automatic offer_cmd(input opcode_t op, input logic [31:0] m, input logic [31:0] b,
                           input logic [2:0] ia, input logic [4:0] oa, input logic lp,
                           input logic pin, input logic [31:0] pw);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    update_mask <= m;
    update_bits <= b;
    in_addr     <= ia;
    out_addr    <= oa;
    last_pair   <= lp;
    pin_valid   <= pin;
    pin_word    <= pw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop offering and hold until every queued latch has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_latches.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_pattern();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'd1 << $urandom_range(31);
      3:       return 32'($urandom_range(16'hFFFF));
      default: return $urandom();
    endcase
  endfunction

  function automatic opcode_t rand_op();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return OP_UPDATE;
    if (r < 55) return OP_RESET;
    if (r < 95) return OP_CONNECT;
    return OP_IGNORE;
  endfunction

  // Offer random commands until n of them have been real (non-ignored) ones
  task automatic run_random(input int unsigned n);
    int unsigned done;
    opcode_t     op;
    done = 0;
    while (done < n) begin
      op = rand_op();
      offer_cmd(op, rand_pattern(), rand_pattern(), 3'($urandom_range(7)),
                5'($urandom_range(31)), 1'($urandom_range(1)), 1'b0, '0);
      if (op != OP_IGNORE) done++;
    end
  endtask

  task automatic add_row(input opcode_t op, input logic [31:0] m, input logic [31:0] b,
                         input logic [2:0] ia, input logic [4:0] oa, input logic lp,
                         input logic pin, input logic [31:0] pw);
    stim_row_t r;
    r.op = op; r.m = m; r.b = b; r.ia = ia; r.oa = oa; r.lp = lp;
    r.pin = pin; r.pin_word = pw;
    directed_q.push_back(r);
  endtask

  initial begin
    // Directed rows: update extremes first, then reset and connect from a
    // known word so the final latches can be worked out by hand.
    add_row(OP_UPDATE,  32'h0000_0000, 32'h0000_0000, 3'd0, 5'd0,  1'b0, 1'b1, 32'h0000_0000);
    add_row(OP_UPDATE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd0, 5'd0,  1'b0, 1'b1, 32'hFFFF_FFFF);
    add_row(OP_UPDATE,  32'hFFFF_FFFF, 32'h0000_0000, 3'd7, 5'd31, 1'b0, 1'b1, 32'h0000_0000);
    add_row(OP_UPDATE,  32'hAAAA_AAAA, 32'hFFFF_FFFF, 3'd0, 5'd0,  1'b0, 1'b1, 32'hAAAA_AAAA);
    add_row(OP_UPDATE,  32'h5555_5555, 32'h5555_5555, 3'd0, 5'd0,  1'b0, 1'b1, 32'hFFFF_FFFF);
    // last flag on an update changes nothing
    add_row(OP_UPDATE,  32'hFFFF_FFFF, 32'h0000_0000, 3'd7, 5'd31, 1'b1, 1'b1, 32'h0000_0000);
    add_row(OP_RESET,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 5'd31, 1'b0, 1'b1, 32'h0000_0030);
    add_row(OP_RESET,   32'h0000_0000, 32'h0000_0000, 3'd0, 5'd0,  1'b1, 1'b1, 32'h0000_0030);
    add_row(OP_CONNECT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd0, 5'd0,  1'b0, 1'b1, 32'h0000_00E0);
    add_row(OP_CONNECT, 32'h0000_0000, 32'h0000_0000, 3'd7, 5'd31, 1'b1, 1'b1, 32'h0000_FE90);
    add_row(OP_CONNECT, 32'h1234_5678, 32'h9ABC_DEF0, 3'd3, 5'd15, 1'b0, 1'b0, '0);
    add_row(OP_CONNECT, 32'hDEAD_BEEF, 32'h0BAD_F00D, 3'd5, 5'd16, 1'b1, 1'b0, '0);
    // unused opcode: nothing should come out
    add_row(OP_IGNORE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 5'd31, 1'b1, 1'b0, '0);
    add_row(OP_IGNORE,  32'h0000_0000, 32'h0000_0000, 3'd0, 5'd0,  1'b0, 1'b0, '0);
    add_row(OP_UPDATE,  32'h0000_0000, 32'hFFFF_FFFF, 3'd0, 5'd0,  1'b0, 1'b0, '0);
    add_row(OP_UPDATE,  32'hFFFF_0000, 32'h1234_5678, 3'd2, 5'd8,  1'b1, 1'b0, '0);
    add_row(OP_CONNECT, 32'h0000_0000, 32'h0000_0000, 3'd2, 5'd8,  1'b0, 1'b0, '0);
    add_row(OP_CONNECT, 32'h0000_0000, 32'h0000_0000, 3'd6, 5'd24, 1'b0, 1'b0, '0);
    add_row(OP_RESET,   32'h0F0F_0F0F, 32'hF0F0_F0F0, 3'd1, 5'd17, 1'b1, 1'b0, '0);
    add_row(OP_CONNECT, 32'h0000_0000, 32'h0000_0000, 3'd1, 5'd23, 1'b1, 1'b0, '0);
    add_row(OP_UPDATE,  32'h8000_0001, 32'h8000_0001, 3'd4, 5'd4,  1'b0, 1'b0, '0);

    // Hold reset, then release it
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Phase one: sender seldom idles, receiver stalls most of the time
    send_gap_pct   = 7;
    recv_stall_pct = 65;
    foreach (directed_q[i])
      offer_cmd(directed_q[i].op, directed_q[i].m, directed_q[i].b, directed_q[i].ia,
                directed_q[i].oa, directed_q[i].lp, directed_q[i].pin,
                directed_q[i].pin_word);
    run_random(150);
    // Pause the sender until every outstanding word has been seen
    wait_drained();

    // Phase two: roles swapped
    send_gap_pct   = 65;
    recv_stall_pct = 7;
    run_random(150);
    wait_drained();

    // Phase three: no idling; start with a long output hold-off while the
    // sender keeps pushing, so the block fills and stalls its input
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    hold_req <= 1'b1;
    run_random(12);
    run_random(138);

    // Drain, then allow the block's latency for any stray words to show up
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d command transactions (%0d with the unused opcode) and %0d",
             cmds_taken, ignored_cnt, words_checked);
    $display("latched words, over swapped idling, a long output hold-off (%0d input stalls).",
             in_stall_cycles);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest correct run
  initial begin
    #8_000_000;
    $display("%0t: timed out with %0d latched words outstanding", $time,
             pending_latches.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
